// ----- hdl/ske_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_pkg: shared types and constants of the sorted key set engine
// Holds the set capacity, the derived widths, the item formats of both
// channels and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ske_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int FIELD_W  = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] entry_count;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic probe_rd;
    logic probe_upd;
    logic chk_rd;
    logic chk_eval;
    logic shift_step;
    logic commit;
    logic rsp_load;
  } ske_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_zero;
    logic do_op;
    logic shift_done;
  } ske_sts_t;

endpackage

// ----- hdl/sorted_key_set_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_engine_core: ordered set of distinct keys
// Each request item inserts or removes one 31-bit key; the set stays sorted
// in a RAM and each item returns one response item.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries an action and a
//   key. The response channel (rsp_valid, rsp_stall, rsp) carries a status,
//   the lower-bound position of the key and the entry count after the item.
//   An item is taken at a clock edge with valid high and stall low.
//   One item is in work at a time. The lower bound is found by a binary
//   search in which every probe is a RAM read and a compare; a set of N
//   entries takes P probes, at most ceil(log2(N + 1)), so at most 7 for 64
//   entries. An insert or remove moves the M entries above the position
//   through the RAM, one entry a cycle. The next item is taken in the cycle
//   after the response is loaded. The response sits in an output register;
//   the next request item is taken as soon as the sequencer is idle, even
//   while that response is stalled. A new response waits in the sequencer
//   until the register is free. Reset empties the set at once; key storage
//   is not cleared, since only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_set_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  ske_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ske_pkg::rsp_item_t rsp
);

  // Command and status groups between the sequencer and the datapath.
  ske_pkg::ske_cmd_t cmd;
  ske_pkg::ske_sts_t sts;

  // The sequencer decides what happens each cycle and owns both handshakes.
  ske_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the keys, the fill count and the response register.
  ske_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cmd(cmd),
    .sts(sts),
    .rsp(rsp)
  );

endmodule

// ----- hdl/ske_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ske_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ske_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_datapath: key storage, search registers and entry mover
// Holds the key memory, the fill count, the lower-bound search window, the
// shift cursor and the result register, all stepped by controller commands.
// ----------------------------------------------------------------------------
module ske_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ske_pkg::req_item_t req,
  input  ske_pkg::ske_cmd_t  cmd,
  output ske_pkg::ske_sts_t  sts,
  output ske_pkg::rsp_item_t rsp
);

  logic                       action;
  logic [ske_pkg::KEY_W-1:0]  key;
  logic [ske_pkg::CNT_W-1:0]  fill;
  logic [ske_pkg::CNT_W-1:0]  first;
  logic [ske_pkg::CNT_W-1:0]  span;
  logic [ske_pkg::CNT_W-1:0]  probe;
  logic [ske_pkg::CNT_W-1:0]  src;
  logic [ske_pkg::CNT_W-1:0]  dst;
  logic [ske_pkg::CNT_W-1:0]  rem;
  logic                       pend;
  ske_pkg::status_t           status;

  logic [ske_pkg::CNT_W-1:0]  half;
  logic [ske_pkg::CNT_W-1:0]  probe_c;
  logic                       hit;
  ske_pkg::status_t           status_c;

  logic                       wr_en;
  logic [ske_pkg::IDX_W-1:0]  wr_addr;
  logic [ske_pkg::KEY_W-1:0]  wr_data;
  logic                       rd_en;
  logic [ske_pkg::IDX_W-1:0]  rd_addr;
  logic [ske_pkg::KEY_W-1:0]  rd_data;

  ske_ram #(
    .WIDTH(ske_pkg::KEY_W),
    .DEPTH(ske_pkg::CAPACITY)
  ) u_keys (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign half    = span >> 1;
  assign probe_c = first + half;

  // The entry at the lower bound is a hit only if it lies inside the set.
  assign hit = (first < fill) && (rd_data == key);

  always_comb begin
    if (action == ske_pkg::ACT_INSERT) begin
      if (hit) begin
        status_c = ske_pkg::STATUS_MISS;
      end else if (fill == ske_pkg::CNT_W'(ske_pkg::CAPACITY)) begin
        status_c = ske_pkg::STATUS_FULL;
      end else begin
        status_c = ske_pkg::STATUS_DONE;
      end
    end else begin
      status_c = hit ? ske_pkg::STATUS_DONE : ske_pkg::STATUS_MISS;
    end
  end

  assign sts.span_zero  = (span == '0);
  assign sts.do_op      = (status_c == ske_pkg::STATUS_DONE);
  assign sts.shift_done = (rem == '0) && !pend;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd.probe_rd) begin
      rd_en   = 1'b1;
      rd_addr = probe_c[ske_pkg::IDX_W-1:0];
    end else if (cmd.chk_rd) begin
      rd_en   = 1'b1;
      rd_addr = first[ske_pkg::IDX_W-1:0];
    end else if (cmd.shift_step && (rem != '0)) begin
      rd_en   = 1'b1;
      rd_addr = src[ske_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    priority if (cmd.shift_step && pend) begin
      wr_en   = 1'b1;
      wr_addr = dst[ske_pkg::IDX_W-1:0];
    end else if (cmd.commit && (action == ske_pkg::ACT_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = first[ske_pkg::IDX_W-1:0];
      wr_data = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
      rem  <= '0;
    end else begin
      if (cmd.load) begin
        action <= req.action;
        key    <= req.key;
        first  <= '0;
        span   <= fill;
      end
      if (cmd.probe_rd) begin
        probe <= probe_c;
      end
      if (cmd.probe_upd) begin
        if (rd_data < key) begin
          first <= probe + ske_pkg::CNT_W'(1);
          span  <= span - half - ske_pkg::CNT_W'(1);
        end else begin
          span <= half;
        end
      end
      if (cmd.chk_eval) begin
        status <= status_c;
        pend   <= 1'b0;
        if (action == ske_pkg::ACT_INSERT) begin
          src <= fill - ske_pkg::CNT_W'(1);
          rem <= fill - first;
        end else begin
          src <= first + ske_pkg::CNT_W'(1);
          rem <= fill - first - ske_pkg::CNT_W'(1);
        end
      end
      if (cmd.shift_step) begin
        if (rem != '0) begin
          pend <= 1'b1;
          rem  <= rem - ske_pkg::CNT_W'(1);
          if (action == ske_pkg::ACT_INSERT) begin
            dst <= src + ske_pkg::CNT_W'(1);
            src <= src - ske_pkg::CNT_W'(1);
          end else begin
            dst <= src - ske_pkg::CNT_W'(1);
            src <= src + ske_pkg::CNT_W'(1);
          end
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.commit) begin
        if (action == ske_pkg::ACT_INSERT) begin
          fill <= fill + ske_pkg::CNT_W'(1);
        end else begin
          fill <= fill - ske_pkg::CNT_W'(1);
        end
      end
      if (cmd.rsp_load) begin
        rsp.status      <= status;
        rsp.position    <= ske_pkg::FIELD_W'(first);
        rsp.entry_count <= ske_pkg::FIELD_W'(fill);
      end
    end
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= ske_pkg::CNT_W'(ske_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_probe_inside : assert property (@(posedge clk) disable iff (rst)
    cmd.probe_rd |-> (probe_c < fill))
    else $error("search probe outside the held entries");

  a_commit_settled : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.shift_done)
    else $error("commit while entries are still moving");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (action == ske_pkg::ACT_INSERT))
      |=> (fill == $past(fill) + ske_pkg::CNT_W'(1)))
    else $error("insert did not grow the set by one");

endmodule

// ----- hdl/ske_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ske_ctrl: sequencing state machine of the sorted key set engine
// Steps the datapath through search, hit check, entry move and result load,
// and owns the request stall and the result valid.
// ----------------------------------------------------------------------------
module ske_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  ske_pkg::ske_sts_t sts,
  output ske_pkg::ske_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PROBE_RD,
    PROBE_CMP,
    CHK_EVAL,
    SHIFT,
    RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (req_valid && !req_stall) begin
          cmd.load   = 1'b1;
          state_next = PROBE_RD;
        end
      end
      PROBE_RD: begin
        if (sts.span_zero) begin
          cmd.chk_rd = 1'b1;
          state_next = CHK_EVAL;
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = PROBE_CMP;
        end
      end
      PROBE_CMP: begin
        cmd.probe_upd = 1'b1;
        state_next    = PROBE_RD;
      end
      CHK_EVAL: begin
        cmd.chk_eval = 1'b1;
        state_next   = sts.do_op ? SHIFT : RESULT;
      end
      SHIFT: begin
        if (sts.shift_done) begin
          cmd.commit = 1'b1;
          state_next = RESULT;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      RESULT: begin
        if (rsp_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      req_stall <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != IDLE);
      if (cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while an item is in work");

  a_stall_matches_state : assert property (@(posedge clk) disable iff (rst)
    req_stall == (state != IDLE))
    else $error("request stall out of step with the sequencer");

  a_rsp_held : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled response dropped");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted key set engine
// Sends insert and remove items, keeps its own sorted copy of the set to work
// out the status, lower-bound position and entry count of every response
// item, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

  // Item counts at which the idling pattern changes. The first stretch has a
  // busy receiver, the second a lazy sender, the last runs at full speed.
  localparam int PHASE1_START = 570;
  localparam int PHASE2_START = 1140;

  // Long receiver hold-offs: the engine keeps one response in its output
  // register and one in the sequencer, so the request side stalls soon.
  localparam int HOLD1_AT    = 300;
  localparam int HOLD2_AT    = 1200;
  localparam int HOLD_CYCLES = 300;

  // Covers the tail after the last item.
  localparam int DRAIN_CYCLES = 100;

  localparam int POOL_SIZE    = 96;
  localparam int RANDOM_ITEMS = 1550;
  localparam int BLOCK_ITEMS  = 150;
  localparam logic [ske_pkg::KEY_W-1:0] KEY_TOP = {ske_pkg::KEY_W{1'b1}};

  // A queued request, or a marker that holds the sender back until every
  // response already owed has come back.
  typedef struct packed {
    logic               wait_idle;
    ske_pkg::req_item_t body;
  } pending_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  ske_pkg::req_item_t req = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  ske_pkg::rsp_item_t rsp;

  pending_req_t       pending_req_q[$];
  ske_pkg::rsp_item_t expected_rsp_q[$];

  // Counters written only with nonblocking assignments, so any process that
  // reads them at a clock edge sees the value from before that edge.
  int acc_count = 0;
  int chk_count = 0;
  int hold_left = 0;
  int holds_done = 0;

  int total_items = 0;
  int err_count = 0;

  // Shadow copy of the set, kept in ascending order in entries below
  // held_count, plus a few tallies for the closing summary.
  logic [ske_pkg::KEY_W-1:0] held_keys[ske_pkg::CAPACITY];
  int unsigned               held_count = 0;
  int n_stored = 0;
  int n_removed = 0;
  int n_refused = 0;
  int n_full = 0;
  int max_fill = 0;

  logic [ske_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  sorted_key_set_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the shadow set and returns the response it owes.
  // The lower bound is the first entry not below the key. A duplicate insert
  // is refused before the capacity check, so it reports a miss even when the
  // set is full; position is the lower bound in every case.
  function automatic ske_pkg::rsp_item_t predict_set_op(ske_pkg::req_item_t op);
    int unsigned        lo;
    int unsigned        span;
    int unsigned        half;
    int unsigned        probe;
    int unsigned        slot;
    logic               found;
    ske_pkg::rsp_item_t res;
    lo = 0;
    span = held_count;
    while (span != 0) begin
      half = span / 2;
      probe = lo + half;
      if (held_keys[probe] < op.key) begin
        lo = probe + 1;
        span = span - half - 1;
      end else begin
        span = half;
      end
    end
    found = (lo < held_count) && (held_keys[lo] == op.key);
    res.status = ske_pkg::STATUS_DONE;
    res.position = lo[ske_pkg::FIELD_W-1:0];
    if (op.action == ske_pkg::ACT_INSERT) begin
      if (found) begin
        res.status = ske_pkg::STATUS_MISS;
        n_refused++;
      end else if (held_count >= ske_pkg::CAPACITY) begin
        res.status = ske_pkg::STATUS_FULL;
        n_full++;
      end else begin
        for (slot = held_count; slot > lo; slot--) begin
          held_keys[slot] = held_keys[slot-1];
        end
        held_keys[lo] = op.key;
        held_count++;
        n_stored++;
      end
    end else begin
      if (!found) begin
        res.status = ske_pkg::STATUS_MISS;
        n_refused++;
      end else begin
        for (slot = lo; slot + 1 < held_count; slot++) begin
          held_keys[slot] = held_keys[slot+1];
        end
        held_count--;
        n_removed++;
      end
    end
    if (held_count > max_fill) begin
      max_fill = held_count;
    end
    res.entry_count = held_count[ske_pkg::FIELD_W-1:0];
    return res;
  endfunction

  // Idle probability in percent for either side, by phase of the run.
  function automatic int unsigned idle_pct(bit rx_side);
    if (acc_count < PHASE1_START) begin
      return rx_side ? 71 : 13;
    end
    if (acc_count < PHASE2_START) begin
      return rx_side ? 13 : 71;
    end
    return 0;
  endfunction

  task automatic add_item(logic action, logic [ske_pkg::KEY_W-1:0] key);
    pending_req_t slot;
    slot.wait_idle = 1'b0;
    slot.body.action = action;
    slot.body.key = key;
    pending_req_q.insert(pending_req_q.size(), slot);
    total_items++;
  endtask

  task automatic add_pause();
    pending_req_t slot;
    slot = '0;
    slot.wait_idle = 1'b1;
    pending_req_q.insert(pending_req_q.size(), slot);
  endtask

  // Request driver. An accepted item is run through the shadow set at the
  // edge that takes it. A new item is only put up once the current one has
  // gone, so a stalled payload never changes and valid never looks at stall.
  always @(posedge clk) begin : drive_req
    pending_req_t next_slot;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsp_q.insert(expected_rsp_q.size(), predict_set_op(req));
        acc_count <= acc_count + 1;
      end
      if (!req_valid || !req_stall) begin
        if (pending_req_q.size() != 0 && pending_req_q[0].wait_idle) begin
          // Nothing in flight and every owed response seen: drop the marker.
          req_valid <= 1'b0;
          if (!req_valid && acc_count == chk_count) begin
            next_slot = pending_req_q.pop_front();
          end
        end else if (pending_req_q.size() != 0 &&
                     $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          next_slot = pending_req_q.pop_front();
          req <= next_slot.body;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response stall. Two long hold-offs are counted out here while the sender
  // keeps offering items; otherwise the stall follows the phase's rate.
  always @(posedge clk) begin : stall_rsp
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 &&
                 acc_count >= ((holds_done == 0) ? HOLD1_AT : HOLD2_AT)) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct(1'b1));
    end
  end

  // Response monitor: every accepted response is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_rsp
    ske_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: response with nothing expected: status %0d position %0d count %0d",
                 $time, rsp.status, rsp.position, rsp.entry_count);
        err_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        chk_count <= chk_count + 1;
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
          err_count++;
        end
        if (rsp.position !== want.position) begin
          $display("%0t: position expected %0d, got %0d",
                   $time, want.position, rsp.position);
          err_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d, got %0d",
                   $time, want.entry_count, rsp.entry_count);
          err_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int idx;
    int swap_idx;
    int ins_pct;
    int target;
    int order[POOL_SIZE];
    logic [ske_pkg::KEY_W-1:0] key;
    logic action;

    // Directed part: empty-set miss, both key extremes, a duplicate insert,
    // removes at the bottom and top, and emptying the set again.
    add_item(ske_pkg::ACT_REMOVE, 31'd5);
    add_item(ske_pkg::ACT_INSERT, KEY_TOP);
    add_item(ske_pkg::ACT_INSERT, 31'd0);
    add_item(ske_pkg::ACT_INSERT, 31'd0);
    add_item(ske_pkg::ACT_INSERT, KEY_TOP - 31'd1);
    add_item(ske_pkg::ACT_INSERT, 31'h2AAA_AAAA);
    add_item(ske_pkg::ACT_INSERT, 31'h5555_5555);
    add_item(ske_pkg::ACT_REMOVE, 31'h0001_2345);
    add_item(ske_pkg::ACT_REMOVE, KEY_TOP);
    add_item(ske_pkg::ACT_REMOVE, 31'd0);
    add_item(ske_pkg::ACT_INSERT, KEY_TOP);
    add_item(ske_pkg::ACT_INSERT, KEY_TOP);
    add_item(ske_pkg::ACT_REMOVE, 31'h2AAA_AAAA);
    add_item(ske_pkg::ACT_REMOVE, 31'h5555_5555);
    add_item(ske_pkg::ACT_REMOVE, KEY_TOP - 31'd1);
    add_item(ske_pkg::ACT_REMOVE, KEY_TOP);
    add_item(ske_pkg::ACT_REMOVE, KEY_TOP);
    add_item(ske_pkg::ACT_INSERT, 31'd1);
    add_item(ske_pkg::ACT_REMOVE, 31'd1);
    add_pause();

    // A pool of keys gives the random part plenty of hits; the extremes are
    // always in it.
    for (idx = 0; idx < POOL_SIZE; idx++) begin
      key_pool[idx] = ske_pkg::KEY_W'($urandom());
      order[idx] = idx;
    end
    key_pool[0] = '0;
    key_pool[1] = KEY_TOP;
    key_pool[2] = 31'd1;
    key_pool[3] = KEY_TOP - 31'd1;

    // Fill the set past capacity: the later inserts hit a full set, then a
    // present key goes in again, which must report a duplicate, not full.
    for (idx = 0; idx < 80; idx++) begin
      add_item(ske_pkg::ACT_INSERT, key_pool[idx]);
    end
    add_item(ske_pkg::ACT_INSERT, key_pool[$urandom_range(0, 63)]);
    add_item(ske_pkg::ACT_INSERT, ske_pkg::KEY_W'($urandom()));
    add_pause();

    // Remove pool keys again in a shuffled order; this need not empty the set.
    for (idx = POOL_SIZE - 1; idx > 0; idx--) begin
      swap_idx = $urandom_range(0, idx);
      target = order[idx];
      order[idx] = order[swap_idx];
      order[swap_idx] = target;
    end
    for (idx = 0; idx < 80; idx++) begin
      add_item(ske_pkg::ACT_REMOVE, key_pool[order[idx]]);
    end
    add_pause();

    // Blocks that lean toward inserts, toward removes, or neither, so the
    // fill level swings between empty and full. Most keys come from the
    // pool; the rest are arbitrary 31-bit values.
    while (total_items + BLOCK_ITEMS <= RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          ins_pct = 80;
        end
        1: begin
          ins_pct = 20;
        end
        default: begin
          ins_pct = 50;
        end
      endcase
      for (idx = 0; idx < BLOCK_ITEMS; idx++) begin
        action = ($urandom_range(0, 99) < ins_pct) ? ske_pkg::ACT_INSERT
                                                   : ske_pkg::ACT_REMOVE;
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          key = ske_pkg::KEY_W'($urandom());
        end
        add_item(action, key);
      end
      add_pause();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (acc_count != total_items || chk_count != total_items) begin
      @(posedge clk);
    end
    // Catch any stray response that shows up after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d keys stored, %0d removed, %0d refused as present or absent",
             total_items, n_stored, n_removed, n_refused);
    $display("Inserts refused on a full set: %0d; largest fill seen: %0d of %0d",
             n_full, max_fill, ske_pkg::CAPACITY);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin : watchdog
    #8000000;
    $display("Timeout with %0d of %0d items checked", chk_count, total_items);
    $display("Mismatches found");
    $finish;
  end

endmodule
